/* hw/rtl/swts_pkg.sv */
// shared types and codes for the sorted word table search block
`default_nettype none

package swts_pkg;

  localparam int WORD_PORT_BITS = 64;
  localparam int POS_BITS = 10;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [1:0] ORD_ASC  = 2'd1;
  localparam logic [1:0] ORD_DESC = 2'd2;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    SEL_REPORT,
    SEL_FOUND,
    SEL_MISS,
    SEL_REFUSED
  } sel_t;

  typedef struct packed {
    logic load;
    logic search;
    logic probe;
    logic out_load;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic refuse;
    logic hit;
    logic empty;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/swts_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module swts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/swts_ctrl.sv */
// controller state machine for load, search probing and result hand-off
`default_nettype none

module swts_ctrl
  import swts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic op,
  input  wire logic final_word,
  output logic      out_valid,
  input  wire logic out_stall,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic [5:0] {
    IDLE    = 6'b000001,
    REPORT  = 6'b000010,
    PROBE   = 6'b000100,
    FOUND   = 6'b001000,
    MISS    = 6'b010000,
    REFUSE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.search   = 1'b0;
    cmd.probe    = 1'b0;
    cmd.out_load = 1'b0;
    cmd.sel      = SEL_REPORT;
    case (state)
      IDLE: begin
        if (in_valid) begin
          if (op == OP_LOAD) begin
            cmd.load = 1'b1;
            if (final_word) begin
              state_next = REPORT;
            end
          end else begin
            cmd.search = 1'b1;
            state_next = sts.refuse ? REFUSE : PROBE;
          end
        end
      end
      PROBE: begin
        cmd.probe = 1'b1;
        if (sts.hit) begin
          state_next = FOUND;
        end else if (sts.empty) begin
          state_next = MISS;
        end
      end
      REPORT, FOUND, MISS, REFUSE: begin
        case (state)
          FOUND:   cmd.sel = SEL_FOUND;
          MISS:    cmd.sel = SEL_MISS;
          REFUSE:  cmd.sel = SEL_REFUSED;
          default: cmd.sel = SEL_REPORT;
        endcase
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_final_reports: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && in_valid && op == OP_LOAD && final_word) |=> state == REPORT)
    else $error("final load did not lead to an order report");

  a_refuse_path: assert property (@(posedge clk) disable iff (rst)
    (cmd.search && sts.refuse) |=> (state == REFUSE && !cmd.probe))
    else $error("refused search entered probing");

endmodule

`default_nettype wire

/* hw/rtl/swts_dp.sv */
// datapath: table store, order tracking, binary search registers, result register
`default_nettype none

module swts_dp
  import swts_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [WORD_PORT_BITS-1:0] word,
  input  wire logic                      final_word,
  input  wire cmd_t                      cmd,
  output sts_t                           sts,
  output logic                           kind,
  output logic [1:0]                     order,
  output logic [1:0]                     status,
  output logic [POS_BITS-1:0]            position
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [WORD_BITS-1:0] w;
  logic [WORD_BITS-1:0] prev;
  logic [WORD_BITS-1:0] key;
  logic [WORD_BITS-1:0] rd_data;
  logic [CW-1:0]        count;
  logic                 table_open;
  logic                 asc;
  logic                 desc;
  logic [1:0]           table_order;

  logic [CW-1:0]        cnt_eff;
  logic                 asc_eff, desc_eff, asc_next, desc_next;
  logic                 room;
  logic [1:0]           order_next;

  logic [CW-1:0]        lo, hi1, lo_next, hi1_next;
  logic [IW-1:0]        mid, mid0, mid_next, rd_addr;
  logic [CW:0]          sum0, sum_next;

  assign w = word[WORD_BITS-1:0];

  // table load and order tracking
  always_comb begin
    cnt_eff  = table_open ? count : '0;
    asc_eff  = table_open ? asc : 1'b1;
    desc_eff = table_open ? desc : 1'b1;
    room     = cnt_eff < CW'(TABLE_DEPTH);
    asc_next  = asc_eff;
    desc_next = desc_eff;
    if (room && cnt_eff != '0) begin
      if (prev > w) asc_next = 1'b0;
      if (prev < w) desc_next = 1'b0;
    end
    if (asc_next && !desc_next) begin
      order_next = ORD_ASC;
    end else if (!asc_next && desc_next) begin
      order_next = ORD_DESC;
    end else begin
      order_next = ORD_NONE;
    end
  end

  // search probe arithmetic, range kept as [lo, hi1)
  always_comb begin
    sum0 = {1'b0, count} - (CW+1)'(1);
    mid0 = sum0[IW:1];
    if (key < rd_data) begin
      lo_next  = lo;
      hi1_next = CW'(mid);
    end else begin
      lo_next  = CW'(mid) + CW'(1);
      hi1_next = hi1;
    end
    sum_next = {1'b0, lo_next} + {1'b0, hi1_next} - (CW+1)'(1);
    mid_next = sum_next[IW:1];
    rd_addr  = cmd.probe ? mid_next : mid0;
  end

  assign sts.refuse = (table_order != ORD_ASC) || (count == '0);
  assign sts.hit    = (key == rd_data);
  assign sts.empty  = (lo_next >= hi1_next);

  swts_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.load && room),
    .wr_addr(cnt_eff[IW-1:0]),
    .wr_data(w),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_open  <= 1'b0;
      count       <= '0;
      asc         <= 1'b1;
      desc        <= 1'b1;
      table_order <= ORD_NONE;
    end else if (cmd.load) begin
      table_open  <= !final_word;
      count       <= room ? cnt_eff + CW'(1) : cnt_eff;
      asc         <= asc_next;
      desc        <= desc_next;
      table_order <= final_word ? order_next : ORD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      prev <= w;
    end
    if (cmd.search) begin
      key <= w;
      lo  <= '0;
      hi1 <= count;
      mid <= mid0;
    end else if (cmd.probe && !sts.hit) begin
      lo  <= lo_next;
      hi1 <= hi1_next;
      mid <= mid_next;
    end
    if (cmd.out_load) begin
      order <= table_order;
      case (cmd.sel)
        SEL_FOUND: begin
          kind     <= KIND_SEARCH;
          status   <= ST_FOUND;
          position <= POS_BITS'(mid);
        end
        SEL_MISS: begin
          kind     <= KIND_SEARCH;
          status   <= ST_MISS;
          position <= '0;
        end
        SEL_REFUSED: begin
          kind     <= KIND_SEARCH;
          status   <= ST_REFUSED;
          position <= '0;
        end
        default: begin
          kind     <= KIND_REPORT;
          status   <= ST_NONE;
          position <= '0;
        end
      endcase
    end
  end

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    cmd.probe |-> lo < hi1)
    else $error("probe issued on an empty range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("word count beyond table depth");

  a_hit_holds_mid: assert property (@(posedge clk) disable iff (rst)
    (cmd.probe && sts.hit) |=> mid == $past(mid))
    else $error("match index lost after hit");

endmodule

`default_nettype wire

/* hw/rtl/sorted_word_table_search.sv */
// top level of the sorted word table search block
//
// input channel: in_valid / in_stall with op, word and final_word per item.
//   a load item (op 0) writes word to the table if not full; the load that
//   carries final_word closes the table and yields one order report.
//   a search item (op 1) runs a binary search over an ascending table.
// output channel: out_valid / out_stall with kind, order, status, position.
// a non-final load yields nothing; a final load yields its order report;
//   a search runs one probe per cycle, up to clog2(TABLE_DEPTH+1) probes
//   (11 at depth 1024); a refused search runs no probes.
// the probe loop is set by the single read port of the table memory, one
//   registered read per probe, the next address chosen from each compare.
// one item is in work at a time; a result waiting in the output register
//   does not keep the block from taking the next item, but a new result
//   waits until the held one is taken while out_stall is high.
// reset clears the order state and the word count; table contents stay
//   undefined until loaded, searches are refused until an ascending table.
`default_nettype none

module sorted_word_table_search
  import swts_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int WORD_BITS   = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      op,
  input  wire logic [WORD_PORT_BITS-1:0] word,
  input  wire logic                      final_word,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           kind,
  output logic [1:0]                     order,
  output logic [1:0]                     status,
  output logic [POS_BITS-1:0]            position
);

  cmd_t cmd;
  sts_t sts;

  swts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .final_word(final_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  swts_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .final_word(final_word),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (kind),
    .order     (order),
    .status    (status),
    .position  (position)
  );

endmodule

`default_nettype wire

/* tb/sv/sorted_word_table_search_check.sv */
// checker for the sorted word table search block: predicts each result and compares it
`timescale 1ns / 1ps

module sorted_word_table_search_check
  import swts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic                      op,
  input  wire logic [WORD_PORT_BITS-1:0] word,
  input  wire logic                      final_word,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic                      kind,
  input  wire logic [1:0]                order,
  input  wire logic [1:0]                status,
  input  wire logic [POS_BITS-1:0]       position,
  output int                             errors,
  output int                             pending,
  output int                             found_count,
  output int                             miss_count,
  output int                             refused_count
);

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic                kind;
    logic [1:0]          order;
    logic [1:0]          status;
    logic [POS_BITS-1:0] position;
  } answer_t;

  answer_t                   answers_q[$];
  logic [WORD_PORT_BITS-1:0] words_mem [0:DEPTH-1];
  int                        word_total;
  logic [WORD_PORT_BITS-1:0] last_word;
  logic                      no_fall;
  logic                      no_rise;
  logic                      loading;
  logic [1:0]                cur_order;

  initial begin
    errors = 0;
    pending = 0;
    found_count = 0;
    miss_count = 0;
    refused_count = 0;
  end

  always @(posedge clk) begin : watch
    int      lo;
    int      hi;
    int      mid;
    logic    done;
    answer_t want;
    answer_t got;
    if (rst) begin
      word_total = 0;
      last_word = '0;
      no_fall = 1'b1;
      no_rise = 1'b1;
      loading = 1'b0;
      cur_order = ORD_NONE;
      answers_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kind, order, status, position};
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d order %0d status %0d position %0d",
                   $time, got.kind, got.order, got.status, got.position);
          errors <= errors + 1;
        end else begin
          want = answers_q.pop_front();
          if (got.kind !== want.kind || got.order !== want.order ||
              got.status !== want.status || got.position !== want.position) begin
            $display("%0t: expected kind %0d order %0d status %0d position %0d, got kind %0d order %0d status %0d position %0d",
                     $time, want.kind, want.order, want.status, want.position,
                     got.kind, got.order, got.status, got.position);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = '0;
        if (op == OP_SEARCH) begin
          want.kind = KIND_SEARCH;
          want.order = cur_order;
          want.status = ST_REFUSED;
          if (cur_order == ORD_ASC && word_total > 0) begin
            want.status = ST_MISS;
            lo = 0;
            hi = word_total - 1;
            done = 1'b0;
            while (lo <= hi && !done) begin
              mid = (lo + hi) / 2;
              if (word == words_mem[mid]) begin
                want.status = ST_FOUND;
                want.position = POS_BITS'(mid);
                done = 1'b1;
              end else if (word < words_mem[mid]) begin
                hi = mid - 1;
              end else begin
                lo = mid + 1;
              end
            end
          end
          case (want.status)
            ST_FOUND: found_count <= found_count + 1;
            ST_MISS:  miss_count <= miss_count + 1;
            default:  refused_count <= refused_count + 1;
          endcase
          answers_q.push_back(want);
        end else begin
          if (!loading) begin
            loading = 1'b1;
            word_total = 0;
            no_fall = 1'b1;
            no_rise = 1'b1;
            cur_order = ORD_NONE;
          end
          // words past full depth are dropped
          if (word_total < DEPTH) begin
            if (word_total > 0) begin
              if (last_word > word) no_fall = 1'b0;
              if (last_word < word) no_rise = 1'b0;
            end
            words_mem[word_total] = word;
            last_word = word;
            word_total++;
          end
          if (final_word) begin
            loading = 1'b0;
            if (no_fall && !no_rise) cur_order = ORD_ASC;
            else if (!no_fall && no_rise) cur_order = ORD_DESC;
            else cur_order = ORD_NONE;
            want.kind = KIND_REPORT;
            want.order = cur_order;
            want.status = ST_NONE;
            answers_q.push_back(want);
          end
        end
      end
    end
    pending <= answers_q.size();
  end

endmodule

/* tb/sv/sorted_word_table_search_tb.sv */
// testbench top for the sorted word table search block: stimulus, idling and verdict
`timescale 1ns / 1ps

module sorted_word_table_search_tb;
  import swts_pkg::*;

  localparam int IDLE_PCT     = 14;
  localparam int STUCK_LIMIT  = 4000;
  localparam int FULL_WORDS   = 1030;
  localparam int KEPT_MAX     = 1024;
  localparam int RANDOM_ITEMS = 750;
  localparam int DIRECTED     = 24;
  localparam int TAIL_CYCLES  = 20;

  typedef enum int {SHAPE_ASC, SHAPE_DESC, SHAPE_MIXED, SHAPE_FLAT} shape_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      op = OP_LOAD;
  logic [WORD_PORT_BITS-1:0] word = '0;
  logic                      final_word = 1'b0;
  logic                      out_stall = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic                      kind;
  logic [1:0]                order;
  logic [1:0]                status;
  logic [POS_BITS-1:0]       position;

  int   errors;
  int   pending;
  int   found_count;
  int   miss_count;
  int   refused_count;
  logic idling = 1'b1;
  int   stuck = 0;
  int   item_count = 0;
  int   load_items = 0;
  int   search_items = 0;
  int   tables_done = 0;

  logic [WORD_PORT_BITS-1:0] words_sent [0:FULL_WORDS-1];

  sorted_word_table_search u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .word       (word),
    .final_word (final_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .order      (order),
    .status     (status),
    .position   (position)
  );

  sorted_word_table_search_check u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .word          (word),
    .final_word    (final_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .order         (order),
    .status        (status),
    .position      (position),
    .errors        (errors),
    .pending       (pending),
    .found_count   (found_count),
    .miss_count    (miss_count),
    .refused_count (refused_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= idling && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("sorted_word_table_search: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // letters packed from the top byte down, zero padded
  function automatic logic [63:0] text_word(input int chars);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < chars; i++) w[63-8*i -: 8] = 8'($urandom_range(97, 122));
    return w;
  endfunction

  task automatic push_item(input logic o, input logic [63:0] w, input logic f);
    while (idling && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    word <= w;
    final_word <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
    if (o == OP_SEARCH) search_items++;
    else load_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_table(input shape_t shape, input int n);
    logic [63:0] cur;
    logic [63:0] step_max;
    logic [63:0] key;
    logic [63:0] tmp;
    int          kept;
    int          idx;
    kept = (n < KEPT_MAX) ? n : KEPT_MAX;
    cur = rand_word() >> $urandom_range(0, 63);
    case (shape)
      SHAPE_ASC, SHAPE_DESC: begin
        step_max = (~cur) / (kept + 1);
        for (int i = 0; i < kept; i++) begin
          words_sent[i] = cur;
          if ($urandom_range(0, 4) != 0) cur += rand_word() % (step_max + 1);
        end
        if (shape == SHAPE_DESC) begin
          for (int i = 0; i < kept / 2; i++) begin
            tmp = words_sent[i];
            words_sent[i] = words_sent[kept-1-i];
            words_sent[kept-1-i] = tmp;
          end
        end
        for (int i = kept; i < n; i++) words_sent[i] = rand_word();
      end
      SHAPE_MIXED: begin
        for (int i = 0; i < n; i++)
          words_sent[i] = $urandom_range(0, 1) ? rand_word() : text_word($urandom_range(1, 8));
      end
      default: begin
        for (int i = 0; i < n; i++) words_sent[i] = cur;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      // search while the table is still open
      if ($urandom_range(0, 39) == 0)
        push_item(OP_SEARCH, words_sent[$urandom_range(0, kept-1)],
                  1'($urandom_range(0, 1)));
      push_item(OP_LOAD, words_sent[i], i == n - 1);
    end
    repeat ($urandom_range(1, 10)) begin
      idx = $urandom_range(0, kept - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: key = words_sent[idx];
        6:                key = words_sent[idx] + 1;
        7:                key = words_sent[idx] - 1;
        8:                key = text_word($urandom_range(1, 8));
        default:          key = rand_word();
      endcase
      push_item(OP_SEARCH, key, 1'($urandom_range(0, 1)));
    end
    tables_done++;
  endtask

  initial begin
    int     table_no;
    int     pick;
    int     n;
    shape_t shape;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push_item(OP_SEARCH, 64'h0, 1'b0);
    push_item(OP_LOAD, 64'h4100_0000_0000_0000, 1'b1);
    push_item(OP_SEARCH, 64'h4100_0000_0000_0000, 1'b1);
    push_item(OP_LOAD, 64'h0, 1'b0);
    push_item(OP_LOAD, 64'h6361_7400_0000_0000, 1'b0);
    push_item(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    push_item(OP_SEARCH, 64'h0, 1'b0);
    push_item(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_item(OP_SEARCH, 64'h6361_7400_0000_0000, 1'b0);
    push_item(OP_SEARCH, 64'h6361_6200_0000_0000, 1'b0);
    push_item(OP_SEARCH, 64'h1, 1'b1);
    push_item(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    push_item(OP_LOAD, 64'h6361_7400_0000_0000, 1'b0);
    push_item(OP_LOAD, 64'h0, 1'b1);
    push_item(OP_SEARCH, 64'h6361_7400_0000_0000, 1'b0);
    push_item(OP_LOAD, 64'h5, 1'b0);
    push_item(OP_LOAD, 64'h5, 1'b1);
    push_item(OP_LOAD, 64'h1, 1'b0);
    push_item(OP_LOAD, 64'h3, 1'b0);
    push_item(OP_LOAD, 64'h2, 1'b1);
    push_item(OP_LOAD, 64'h1, 1'b0);
    push_item(OP_SEARCH, 64'h1, 1'b0);
    push_item(OP_LOAD, 64'h2, 1'b1);
    push_item(OP_SEARCH, 64'h2, 1'b0);

    table_no = 0;
    while (item_count < DIRECTED + RANDOM_ITEMS + FULL_WORDS) begin
      idling <= !(table_no >= 10 && table_no < 22);
      if (table_no == 4) begin
        run_table(SHAPE_ASC, FULL_WORDS);
        drain();
      end else begin
        pick = $urandom_range(0, 9);
        shape = (pick < 7) ? SHAPE_ASC : (pick == 7) ? SHAPE_DESC :
                (pick == 8) ? SHAPE_MIXED : SHAPE_FLAT;
        if (shape == SHAPE_FLAT) n = $urandom_range(1, 4);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(2, 200);
        else n = $urandom_range(2, 24);
        run_table(shape, n);
      end
      table_no++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d load and %0d search items over %0d tables, one loaded past full depth",
             load_items, search_items, tables_done);
    $display("search answers: %0d found, %0d not found, %0d refused",
             found_count, miss_count, refused_count);
    if (errors == 0 && pending == 0) begin
      $display("sorted_word_table_search: match");
    end else begin
      $display("sorted_word_table_search: mismatch");
    end
    $finish;
  end

endmodule
